>>> sv/gbns_pkg.sv
// Package for the Go-Back-N sender: field widths, event, timer and status codes,
// sequencer states and the payload byte-sum function.
// Depends on nothing; gbns_if, go_back_n_sender and the testbench import it.
package gbns_pkg;

   localparam int BUF_DEPTH_DEF = 64;
   localparam int MAX_WIN       = 64;
   localparam int SEQ_W         = 31;
   localparam int WORD_W        = 32;
   localparam int PAY_W         = 160;
   localparam int BSUM_W        = 13;
   localparam int WIN_W         = 7;
   localparam int HALF_SPACE    = 1 << 30;

   typedef enum logic [1:0] {
      MODE_MSG   = 2'd0,
      MODE_ACK   = 2'd1,
      MODE_TIMER = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      TIMER_NONE    = 2'd0,
      TIMER_START   = 2'd1,
      TIMER_STOP    = 2'd2,
      TIMER_RESTART = 2'd3
   } timer_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ACK = 2'd1,
      ST_FULL    = 2'd2,
      ST_BEYOND  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_CHECK,
      S_DECIDE,
      S_EMIT
   } state_type;

   // Sum of the 20 payload bytes, each taken as a signed 8-bit value.
   function automatic logic signed [BSUM_W-1:0] byte_sum(input logic [PAY_W-1:0] pay);
      logic signed [BSUM_W-1:0] acc;
      logic [7:0]               b;
      acc = '0;
      for (int i = 0; i < PAY_W / 8; i++) begin
         b   = pay[8*i +: 8];
         acc = acc + $signed({{(BSUM_W-8){b[7]}}, b});
      end
      return acc;
   endfunction

endpackage

>>> sv/gbns_if.sv
// Channel interfaces of the Go-Back-N sender: event input, packet output and
// the window-size register write. Depends on gbns_pkg for field widths.
interface gbns_req_if import gbns_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [63:0]              payload_0;
   logic [63:0]              payload_1;
   logic [31:0]              payload_2;
   logic [SEQ_W-1:0]         ack_seq;
   logic signed [WORD_W-1:0] ack_number;
   logic signed [WORD_W-1:0] ack_checksum;

   modport source (output valid, mode, payload_0, payload_1, payload_2,
                   ack_seq, ack_number, ack_checksum, input ready);
   modport sink   (input valid, mode, payload_0, payload_1, payload_2,
                   ack_seq, ack_number, ack_checksum, output ready);
endinterface

interface gbns_rsp_if import gbns_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     send_valid;
   logic [SEQ_W-1:0]         seq_out;
   logic signed [WORD_W-1:0] checksum_out;
   logic [63:0]              data_out_0;
   logic [63:0]              data_out_1;
   logic [31:0]              data_out_2;
   logic [1:0]               timer_action;
   logic [1:0]               status;
   logic                     last;

   modport source (output valid, send_valid, seq_out, checksum_out, data_out_0,
                   data_out_1, data_out_2, timer_action, status, last, input ready);
   modport sink   (input valid, send_valid, seq_out, checksum_out, data_out_0,
                   data_out_1, data_out_2, timer_action, status, last, output ready);
endinterface

interface gbns_csr_if import gbns_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> sv/gbns_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// Read data holds while no read is issued. Depends on nothing.
module gbns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/go_back_n_sender.sv
// Top level of the Go-Back-N ARQ sender.
// Depends on gbns_pkg, the channel interfaces in gbns_if and gbns_ram.
//
// This block is the sending half of a Go-Back-N link. Each input beat is one event:
// a message from the upper layer, an arriving ack, or a timer expiry. Messages are
// kept in a packet store of BUF_DEPTH entries, addressed by a circular slot pointer
// that follows the window base; the store also keeps the signed byte sum of each
// payload so that the outgoing checksum need not sum the payload bytes again. Every
// event produces at least one result beat, and the final beat of an event carries the
// timer command and the status. After an event is accepted it passes the sequencer
// (byte sum, ack check, decision) and then the result path (store read, output
// register) before its first result beat is presented. After that, packets leave at
// one per cycle while the consumer takes them, limited by the single read port of
// the store. An event that sends packets occupies the sequencer until its last packet
// enters the result path. The result path is a two-stage queue (the store's read
// register and the output register), so the next event is taken while earlier
// results still wait for the consumer. The store is not cleared after reset; only
// slots that hold outstanding packets are ever read. The window size register is to
// be written through the csr channel only while the block is idle; the block itself
// does not enforce this. Values outside 1 to min(64, BUF_DEPTH) are clamped into
// that range.
module go_back_n_sender import gbns_pkg::*; #(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   gbns_req_if.sink   req_ch,
   gbns_rsp_if.source rsp_ch,
   gbns_csr_if.sink   csr_ch
);

   localparam int AW  = $clog2(BUF_DEPTH);
   localparam int CW  = $clog2(BUF_DEPTH + 1);
   localparam int KW  = ((CW > WIN_W) ? CW : WIN_W) + 1;
   localparam int CAP = (BUF_DEPTH < MAX_WIN) ? BUF_DEPTH : MAX_WIN;
   localparam int DW  = BSUM_W + PAY_W;

   // Slot arithmetic: the sum stays below twice BUF_DEPTH, so one subtract wraps.
   function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= (AW+1)'(BUF_DEPTH)) ? s - (AW+1)'(BUF_DEPTH) : s;
      return r[AW-1:0];
   endfunction

   // Sequencer and window state.
   state_type                state_ff, state_in;
   logic [WIN_W-1:0]         window_size_ff;
   logic [SEQ_W-1:0]         window_base_ff, window_base_in;
   logic [SEQ_W-1:0]         next_seq_ff, next_seq_in;
   logic [AW-1:0]            base_slot_ff, base_slot_in;
   logic [CW-1:0]            count_ff, count_in;

   // Captured event.
   mode_type                 mode_ff;
   logic [PAY_W-1:0]         pay_ff;
   logic [SEQ_W-1:0]         ack_seq_ff;
   logic [WORD_W-1:0]        ack_num_ff;
   logic [WORD_W-1:0]        ack_cks_ff;
   logic signed [BSUM_W-1:0] bsum_ff;
   logic                     ack_ok_ff;
   logic [SEQ_W-1:0]         dist_ff;

   // Emission range and the window that it is measured from.
   logic [KW-1:0]            k_ff, k_in;
   logic [KW-1:0]            hi_ff, hi_in;
   logic [SEQ_W-1:0]         eb_ff, eb_in;
   logic [AW-1:0]            es_ff, es_in;
   timer_type                timer_ff, timer_in;
   status_type               status_ff, status_in;

   // First result stage: the store's read register plus these side registers.
   logic                     a_valid_ff, a_valid_in;
   logic                     a_send_ff, a_send_in;
   logic [SEQ_W-1:0]         a_seq_ff, a_seq_in;
   logic                     a_last_ff, a_last_in;
   timer_type                a_timer_ff, a_timer_in;
   status_type               a_status_ff, a_status_in;

   // Output register.
   logic                     b_valid_ff;
   logic                     b_send_ff;
   logic [SEQ_W-1:0]         b_seq_ff;
   logic [WORD_W-1:0]        b_cks_ff;
   logic [PAY_W-1:0]         b_data_ff;
   logic [1:0]               b_timer_ff;
   logic [1:0]               b_status_ff;
   logic                     b_last_ff;

   // Store ports.
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [DW-1:0]            rd_data;

   // Working values.
   logic                     req_fire;
   logic                     b_load;
   logic                     a_free;
   logic [KW-1:0]            w_eff;
   logic [KW-1:0]            cnt_k;
   logic [KW-1:0]            dn;
   logic [KW-1:0]            dn_w;
   logic [WORD_W-1:0]        want;
   logic [WORD_W-1:0]        b_cks_in;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   // The output register takes a beat when it is empty or its beat leaves now;
   // the first stage may take a new beat when it is empty or moves on now.
   assign b_load = a_valid_ff && (!b_valid_ff || rsp_ch.ready);
   assign a_free = !a_valid_ff || b_load;

   // Effective window, clamped to 1 .. CAP.
   always_comb begin
      if (window_size_ff == '0) begin
         w_eff = KW'(1);
      end else if (KW'(window_size_ff) > KW'(CAP)) begin
         w_eff = KW'(CAP);
      end else begin
         w_eff = KW'(window_size_ff);
      end
   end

   assign cnt_k = KW'(count_ff);
   // The ack lies below the outstanding count whenever this is used, so the
   // distance fits in the count's width.
   assign dn    = KW'(dist_ff[CW-1:0]) + KW'(1);
   assign dn_w  = dn + w_eff;

   assign want = WORD_W'({1'b0, ack_seq_ff}) + ack_num_ff
                 + {{(WORD_W-BSUM_W){bsum_ff[BSUM_W-1]}}, bsum_ff};

   gbns_ram #(
      .WIDTH (DW),
      .DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({bsum_ff, pay_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = wrap_slot({1'b0, base_slot_ff} + (AW+1)'(count_ff));
   assign rd_addr = wrap_slot({1'b0, es_ff} + k_ff[AW:0]);

   // Sequencer: next state, window updates and the beat pushed into the first stage.
   always_comb begin
      state_in       = state_ff;
      window_base_in = window_base_ff;
      next_seq_in    = next_seq_ff;
      base_slot_in   = base_slot_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      hi_in          = hi_ff;
      eb_in          = eb_ff;
      es_in          = es_ff;
      timer_in       = timer_ff;
      status_in      = status_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      a_valid_in     = a_valid_ff && !b_load;
      a_send_in      = a_send_ff;
      a_seq_in       = a_seq_ff;
      a_last_in      = a_last_ff;
      a_timer_in     = a_timer_ff;
      a_status_in    = a_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // Default: an empty range, so one result without a packet.
            state_in  = S_EMIT;
            k_in      = '0;
            hi_in     = '0;
            eb_in     = window_base_ff;
            es_in     = base_slot_ff;
            timer_in  = TIMER_NONE;
            status_in = ST_OK;
            unique case (mode_ff)
               MODE_MSG: begin
                  if (count_ff >= CW'(BUF_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en       = 1'b1;
                     k_in        = cnt_k;
                     hi_in       = (cnt_k < w_eff) ? cnt_k + KW'(1) : cnt_k;
                     timer_in    = (count_ff == '0) ? TIMER_START : TIMER_NONE;
                     next_seq_in = next_seq_ff + SEQ_W'(1);
                     count_in    = count_ff + CW'(1);
                  end
               end
               MODE_ACK: begin
                  if (!ack_ok_ff) begin
                     status_in = ST_BAD_ACK;
                  end else if (dist_ff >= SEQ_W'(count_ff)) begin
                     status_in = (dist_ff < SEQ_W'(HALF_SPACE)) ? ST_BEYOND : ST_BAD_ACK;
                  end else begin
                     // Packets that newly enter the window, counted from the old base.
                     k_in           = (w_eff > dn) ? w_eff : dn;
                     hi_in          = (cnt_k < dn_w) ? cnt_k : dn_w;
                     window_base_in = window_base_ff + SEQ_W'(dn);
                     base_slot_in   = wrap_slot({1'b0, base_slot_ff} + (AW+1)'(dn));
                     count_in       = count_ff - CW'(dn);
                     timer_in       = (cnt_k == dn) ? TIMER_STOP : TIMER_RESTART;
                  end
               end
               MODE_TIMER: begin
                  hi_in    = (cnt_k < w_eff) ? cnt_k : w_eff;
                  timer_in = TIMER_START;
               end
               MODE_NONE: begin
               end
               default: begin
               end
            endcase
         end
         S_EMIT: begin
            if (a_free) begin
               a_valid_in  = 1'b1;
               a_seq_in    = eb_ff + SEQ_W'(k_ff);
               a_timer_in  = TIMER_NONE;
               a_status_in = ST_OK;
               if (k_ff >= hi_ff) begin
                  // Nothing to send: one empty beat with the timer command.
                  a_send_in   = 1'b0;
                  a_last_in   = 1'b1;
                  a_timer_in  = timer_ff;
                  a_status_in = status_ff;
                  state_in    = S_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  a_send_in = 1'b1;
                  a_last_in = (k_ff + KW'(1) >= hi_ff);
                  k_in      = k_ff + KW'(1);
                  if (k_ff + KW'(1) >= hi_ff) begin
                     a_timer_in  = timer_ff;
                     a_status_in = status_ff;
                     state_in    = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Packet checksum: sequence number, the fixed ack field of -1, and the byte sum.
   assign b_cks_in = WORD_W'({1'b0, a_seq_ff}) + {WORD_W{1'b1}}
                     + {{(WORD_W-BSUM_W){rd_data[DW-1]}}, rd_data[DW-1:PAY_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= WIN_W'(8);
         window_base_ff <= SEQ_W'(1);
         next_seq_ff    <= SEQ_W'(1);
         base_slot_ff   <= '0;
         count_ff       <= '0;
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_base_ff <= window_base_in;
         next_seq_ff    <= next_seq_in;
         base_slot_ff   <= base_slot_in;
         count_ff       <= count_in;
         a_valid_ff     <= a_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            window_size_ff <= csr_ch.data;
         end
         if (b_load) begin
            b_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and working registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= mode_type'(req_ch.mode);
         pay_ff     <= {req_ch.payload_2, req_ch.payload_1, req_ch.payload_0};
         ack_seq_ff <= req_ch.ack_seq;
         ack_num_ff <= req_ch.ack_number;
         ack_cks_ff <= req_ch.ack_checksum;
      end
      if (state_ff == S_SUM) begin
         bsum_ff <= byte_sum(pay_ff);
      end
      if (state_ff == S_CHECK) begin
         ack_ok_ff <= (want == ack_cks_ff) && !ack_num_ff[WORD_W-1];
         dist_ff   <= ack_num_ff[SEQ_W-1:0] - window_base_ff;
      end
      k_ff        <= k_in;
      hi_ff       <= hi_in;
      eb_ff       <= eb_in;
      es_ff       <= es_in;
      timer_ff    <= timer_in;
      status_ff   <= status_in;
      a_send_ff   <= a_send_in;
      a_seq_ff    <= a_seq_in;
      a_last_ff   <= a_last_in;
      a_timer_ff  <= a_timer_in;
      a_status_ff <= a_status_in;
      if (b_load) begin
         b_send_ff   <= a_send_ff;
         b_seq_ff    <= a_send_ff ? a_seq_ff : '0;
         b_cks_ff    <= a_send_ff ? b_cks_in : '0;
         b_data_ff   <= a_send_ff ? rd_data[PAY_W-1:0] : '0;
         b_timer_ff  <= a_timer_ff;
         b_status_ff <= a_status_ff;
         b_last_ff   <= a_last_ff;
      end
   end

   assign rsp_ch.valid        = b_valid_ff;
   assign rsp_ch.send_valid   = b_send_ff;
   assign rsp_ch.seq_out      = b_seq_ff;
   assign rsp_ch.checksum_out = b_cks_ff;
   assign rsp_ch.data_out_0   = b_data_ff[63:0];
   assign rsp_ch.data_out_1   = b_data_ff[127:64];
   assign rsp_ch.data_out_2   = b_data_ff[PAY_W-1:128];
   assign rsp_ch.timer_action = b_timer_ff;
   assign rsp_ch.status       = b_status_ff;
   assign rsp_ch.last         = b_last_ff;

endmodule

>>> dv/tb_go_back_n_sender.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Go-Back-N ARQ sender (go_back_n_sender).
// Needs gbns_pkg, the channel interfaces of gbns_if and the RTL of the block.
module tb_go_back_n_sender;
   import gbns_pkg::*;

   // Run limits. The slowest correct run is roughly 260 events, each at most
   // 64 result beats, every beat waiting out receiver stalls and one long
   // hold-off; the watchdog limit below stays well above such a run.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 500;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned DRAIN       = 80;
   localparam int unsigned DEPTH       = BUF_DEPTH_DEF;
   localparam logic [31:0] NO_ACK      = 32'hFFFF_FFFF;

   // How the ack checksum of a scripted event is produced.
   typedef enum logic [1:0] {
      CK_NONE,   // checksum field left at zero
      CK_GOOD,   // correct additive checksum
      CK_SKEW    // correct checksum plus one
   } ck_kind_type;

   // One event offered on the request channel.
   typedef struct {
      mode_type    mode;
      logic [63:0] p0;
      logic [63:0] p1;
      logic [31:0] p2;
      logic [30:0] aseq;
      logic [31:0] anum;
      logic [31:0] acks;
   } link_evt_type;

   // One result beat as it should leave the block.
   typedef struct {
      logic        send_valid;
      logic [30:0] seq;
      logic [31:0] cks;
      logic [63:0] d0;
      logic [63:0] d1;
      logic [31:0] d2;
      timer_type   tmr;
      status_type  st;
      logic        last;
   } beat_type;

   // A row of the directed script. Rows with typed set carry their single
   // result beat inline; the rest are left to the sender model below.
   typedef struct {
      mode_type    mode;
      logic [63:0] p0;
      logic [63:0] p1;
      logic [31:0] p2;
      logic [30:0] aseq;
      logic [31:0] anum;
      ck_kind_type ck;
      bit          typed;
      timer_type   tmr;
      status_type  st;
   } script_row_type;

   // One phase: window register value, idle and stall rates, length and squeeze.
   typedef struct {
      logic [WIN_W-1:0] win;
      int unsigned      idle_pct;
      int unsigned      stall_pct;
      int unsigned      items;
      bit               squeeze;
   } phase_type;

   logic clock = 1'b0;
   logic reset;
   logic rsp_take = 1'b0;

   gbns_req_if req_ch ();
   gbns_rsp_if rsp_ch ();
   gbns_csr_if csr_ch ();

   assign rsp_ch.ready = rsp_take;

   go_back_n_sender dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Directed script, run from reset with the default window of 8. The
   // sequence numbers in the ack rows follow the state the earlier rows leave.
   script_row_type script [25] = '{
      // Timer expiry with nothing outstanding still restarts the timer.
      '{MODE_TIMER, 64'h0, 64'h0, 32'h0, 31'd0, 32'd0, CK_NONE, 1'b1, TIMER_START, ST_OK},
      // The unused mode gives one empty beat.
      '{MODE_NONE, '1, '1, '1, '1, '1, CK_NONE, 1'b1, TIMER_NONE, ST_OK},
      // Ack number 0 lies below the base of 1.
      '{MODE_ACK, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'h5A5A_A5A5,
        31'd0, 32'd0, CK_GOOD, 1'b1, TIMER_NONE, ST_BAD_ACK},
      // Ack number 1 while nothing has been sent yet.
      '{MODE_ACK, 64'h0, 64'h0, 32'h0, 31'h1234, 32'd1, CK_GOOD, 1'b1, TIMER_NONE, ST_BEYOND},
      // Five messages, sequence numbers 1 to 5, with extreme payload bytes.
      '{MODE_MSG, 64'h0, 64'h0, 32'h0, 31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, '1, '1, '1, 31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, {8{8'h80}}, {8{8'h80}}, {4{8'h80}},
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, {8{8'h7F}}, {8{8'h7F}}, {4{8'h7F}},
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, 32'h7F80_01FE,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      // Corrupted checksum on an otherwise good ack.
      '{MODE_ACK, 64'h1, 64'h2, 32'h3, 31'd7, 32'd1, CK_SKEW, 1'b1, TIMER_NONE, ST_BAD_ACK},
      // Negative ack number with a correct checksum.
      '{MODE_ACK, 64'h0, 64'h0, 32'h0, 31'd9, 32'hFFFF_FFFF, CK_GOOD, 1'b1,
        TIMER_NONE, ST_BAD_ACK},
      // Ack of sequence 6, one past the last packet sent.
      '{MODE_ACK, 64'h0, 64'h0, 32'h0, 31'd2, 32'd6, CK_GOOD, 1'b1, TIMER_NONE, ST_BEYOND},
      // Good ack of 2 moves the base to 3; the timer restarts.
      '{MODE_ACK, 64'hFFFF_0000_FFFF_0000, 64'h0, 32'hFFFF_FFFF,
        31'h7FFF_FFFF, 32'd2, CK_GOOD, 1'b0, TIMER_NONE, ST_OK},
      // Expiry resends 3 to 5.
      '{MODE_TIMER, 64'h0, 64'h0, 32'h0, 31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      // Seven more messages; the last two fall outside the window of 8.
      '{MODE_MSG, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 32'h8000_0001,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 32'hC3C3_3C3C,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_AAAA,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0, 32'h0102_0304,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, 32'hF0F0_0F0F,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h1357_9BDF_2468_ACE0, 64'hFDB9_7531_ECA8_6420, 32'h7777_8888,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      '{MODE_MSG, 64'h8181_8181_7E7E_7E7E, 64'h0000_0001_8000_0000, 32'hFFFF_0000,
        31'd0, 32'd0, CK_NONE, 1'b0, TIMER_NONE, ST_OK},
      // Stale ack of 1 after the base has moved to 3, largest ack sequence field.
      '{MODE_ACK, 64'h0, 64'h0, 32'h0, 31'h7FFF_FFFF, 32'd1, CK_GOOD, 1'b1,
        TIMER_NONE, ST_BAD_ACK},
      // Ack of 4 lets the two held-back packets 11 and 12 into the window.
      '{MODE_ACK, 64'h2, 64'h4, 32'h8, 31'd100, 32'd4, CK_GOOD, 1'b0, TIMER_NONE, ST_OK},
      // Ack of 12 clears the window and stops the timer.
      '{MODE_ACK, 64'h0, 64'h0, 32'h0, 31'd0, 32'd12, CK_GOOD, 1'b0, TIMER_NONE, ST_OK},
      // Expiry on an empty window.
      '{MODE_TIMER, 64'h0, 64'h0, 32'h0, 31'd0, 32'd0, CK_NONE, 1'b1, TIMER_START, ST_OK}
   };

   // Random phases. The window values include both clamped extremes of the
   // 7-bit register (0 and 127) as well as the legal ends 1 and 64.
   phase_type phase_plan [8] = '{
      '{7'd1,   0,  0,  22, 1'b0},
      '{7'd64,  53, 0,  22, 1'b0},
      '{7'd0,   0,  53, 22, 1'b0},
      '{7'd127, 31, 31, 22, 1'b0},
      '{7'd64,  0,  0,  4,  1'b1},
      '{7'd5,   31, 31, 22, 1'b0},
      '{7'd8,   53, 0,  24, 1'b0},
      '{7'd64,  0,  53, 24, 1'b0}
   };

   // Sender model state: window register, window base, next sequence number,
   // the slot of the base in the packet store, and the store itself.
   logic [WIN_W-1:0] win_reg   = 7'd8;
   logic [30:0]      win_base  = 31'd1;
   logic [30:0]      seq_next  = 31'd1;
   int unsigned      base_slot = 0;
   logic [63:0]      store_lo  [DEPTH];
   logic [63:0]      store_mid [DEPTH];
   logic [31:0]      store_hi  [DEPTH];

   beat_type    fresh_beats[$];     // beats caused by the event just accepted
   beat_type    awaited_beats[$];   // beats still owed by the block, oldest first
   int unsigned mismatches   = 0;
   int unsigned idle_pct     = 0;
   int unsigned stall_pct    = 0;
   int unsigned holds_asked  = 0;
   int unsigned holds_done   = 0;
   int unsigned hold_left    = 0;
   int unsigned cycles       = 0;

   // Sum of the 20 payload bytes, each taken as a signed byte, 32-bit wrap.
   function automatic logic [31:0] byte_total(logic [63:0] a, logic [63:0] b,
                                              logic [31:0] c);
      logic [159:0] all;
      logic [31:0]  acc;
      all = {c, b, a};
      acc = '0;
      for (int i = 0; i < 20; i++)
         acc = acc + {{24{all[8*i+7]}}, all[8*i +: 8]};
      return acc;
   endfunction

   function automatic logic [31:0] frame_sum(logic [30:0] seq, logic [31:0] anum,
                                             logic [63:0] a, logic [63:0] b,
                                             logic [31:0] c);
      return {1'b0, seq} + anum + byte_total(a, b, c);
   endfunction

   function automatic int unsigned eff_window();
      int unsigned w;
      int unsigned cap;
      w   = 32'(win_reg);
      cap = (DEPTH < MAX_WIN) ? DEPTH : MAX_WIN;
      if (w < 1)
         w = 1;
      if (w > cap)
         w = cap;
      return w;
   endfunction

   function automatic int unsigned in_flight();
      logic [30:0] o;
      o = seq_next - win_base;
      return {1'b0, o};
   endfunction

   function automatic void emit_packet(logic [30:0] seq, int unsigned slot);
      beat_type b;
      b = '{1'b1, seq, frame_sum(seq, NO_ACK, store_lo[slot], store_mid[slot],
             store_hi[slot]), store_lo[slot], store_mid[slot], store_hi[slot],
             TIMER_NONE, ST_OK, 1'b0};
      fresh_beats = {fresh_beats, b};
   endfunction

   // Applies one event to the sender model and leaves the beats it causes in
   // fresh_beats. The timer command and status ride on the final beat, which
   // is an empty one when no packet goes out.
   function automatic void advance_sender(link_evt_type ev);
      int unsigned w;
      int unsigned o;
      int unsigned d;
      int unsigned lo;
      int unsigned hi;
      int unsigned slot;
      int unsigned old_slot;
      logic [30:0] old_base;
      logic [30:0] gap;
      timer_type   tmr;
      status_type  st;
      beat_type    empty;
      w   = eff_window();
      o   = in_flight();
      tmr = TIMER_NONE;
      st  = ST_OK;
      fresh_beats.delete();
      case (ev.mode)
         MODE_MSG: begin
            if (o >= DEPTH) begin
               st = ST_FULL;
            end else begin
               slot            = (base_slot + o) % DEPTH;
               store_lo[slot]  = ev.p0;
               store_mid[slot] = ev.p1;
               store_hi[slot]  = ev.p2;
               tmr = (o == 0) ? TIMER_START : TIMER_NONE;
               if (o < w)
                  emit_packet(win_base + 31'(o), slot);
               seq_next = seq_next + 31'd1;
            end
         end
         MODE_ACK: begin
            gap = ev.anum[30:0] - win_base;
            if (frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2) != ev.acks ||
                ev.anum[31]) begin
               st = ST_BAD_ACK;
            end else if (gap >= o) begin
               // Numbers within half the sequence space ahead are not yet sent;
               // the rest are stale.
               st = (gap < HALF_SPACE) ? ST_BEYOND : ST_BAD_ACK;
            end else begin
               d        = {1'b0, gap};
               old_base = win_base;
               old_slot = base_slot;
               lo       = (w > d + 1) ? w : d + 1;
               hi       = (o < d + 1 + w) ? o : d + 1 + w;
               win_base  = win_base + 31'(d + 1);
               base_slot = (base_slot + d + 1) % DEPTH;
               tmr = (win_base == seq_next) ? TIMER_STOP : TIMER_RESTART;
               for (int unsigned k = lo; k < hi; k++)
                  emit_packet(old_base + 31'(k), (old_slot + k) % DEPTH);
            end
         end
         MODE_TIMER: begin
            for (int unsigned k = 0; k < o && k < w; k++)
               emit_packet(win_base + 31'(k), (base_slot + k) % DEPTH);
            tmr = TIMER_START;
         end
         default: ;
      endcase
      if (fresh_beats.size() == 0) begin
         empty = '{1'b0, '0, '0, '0, '0, '0, TIMER_NONE, ST_OK, 1'b0};
         fresh_beats = {fresh_beats, empty};
      end
      fresh_beats[fresh_beats.size()-1].tmr  = tmr;
      fresh_beats[fresh_beats.size()-1].st   = st;
      fresh_beats[fresh_beats.size()-1].last = 1'b1;
   endfunction

   // Payload lanes lean toward all-zero, all-one and sign-edge bytes.
   function automatic logic [63:0] rand_lane();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return {8{8'h80}};
         3:       return {8{8'h7F}};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Draws the next random event against the current model state. Most of
   // the traffic is messages, good acks inside the outstanding range and
   // expiries; the rest is corrupted, stale, premature or negative acks and
   // the unused mode.
   function automatic link_evt_type draw_evt();
      link_evt_type ev;
      logic [63:0]  lane;
      logic [31:0]  raw;
      int unsigned  r;
      int unsigned  o;
      o       = in_flight();
      lane    = rand_lane();
      raw     = $urandom();
      ev.mode = MODE_MSG;
      ev.p0   = rand_lane();
      ev.p1   = rand_lane();
      ev.p2   = lane[31:0];
      ev.aseq = raw[30:0];
      ev.anum = '0;
      ev.acks = $urandom();
      r = $urandom_range(99);
      if (r < 45 || (r < 72 && o == 0)) begin
         ev.mode = MODE_MSG;
      end else if (r < 72) begin
         ev.mode = MODE_ACK;
         ev.anum = {1'b0, win_base + 31'($urandom_range(o - 1))};
         ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
      end else if (r < 82) begin
         ev.mode = MODE_TIMER;
      end else begin
         ev.mode = MODE_ACK;
         case ($urandom_range(4))
            0: ev.anum = $urandom();   // checksum left random
            1: begin
               ev.anum = {1'b0, seq_next + 31'($urandom_range(40))};
               ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
            end
            2: begin
               ev.anum = {1'b0, win_base - 31'd1 - 31'($urandom_range(8))};
               ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
            end
            3: begin
               ev.anum = $urandom();
               ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
            end
            default: ev.mode = MODE_NONE;
         endcase
      end
      return ev;
   endfunction

   // Offers one event, with random idle cycles ahead of it, and books its
   // expected beats at the edge that accepts it. Called at a rising edge.
   task automatic offer_evt(input link_evt_type ev, input bit typed = 1'b0,
                            input timer_type tmr = TIMER_NONE,
                            input status_type st = ST_OK);
      beat_type b;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= ev.mode;
      req_ch.payload_0    <= ev.p0;
      req_ch.payload_1    <= ev.p1;
      req_ch.payload_2    <= ev.p2;
      req_ch.ack_seq      <= ev.aseq;
      req_ch.ack_number   <= ev.anum;
      req_ch.ack_checksum <= ev.acks;
      do
         @(posedge clock);
      while (!req_ch.ready);
      advance_sender(ev);
      if (typed) begin
         b = '{1'b0, '0, '0, '0, '0, '0, tmr, st, 1'b1};
         awaited_beats = {awaited_beats, b};
      end else begin
         awaited_beats = {awaited_beats, fresh_beats};
      end
   endtask

   // Waits until every owed beat has come back, then lets the block settle.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (awaited_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_window(input logic [WIN_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      win_reg = value;
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: checks every accepted beat against the oldest owed beat and
   // drives ready. A requested hold-off keeps ready low without a break;
   // otherwise ready drops at random by the stall percentage.
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_ch.valid && rsp_take) begin
         if (awaited_beats.size() == 0) begin
            $error("result beat with nothing owed: seq_out %0h, last %0b",
                   rsp_ch.seq_out, rsp_ch.last);
            mismatches++;
         end else begin
            want = awaited_beats.pop_front();
            check_field("send_valid", 64'(want.send_valid), 64'(rsp_ch.send_valid));
            check_field("seq_out", 64'(want.seq), 64'(rsp_ch.seq_out));
            check_field("checksum_out", 64'(want.cks), 64'($unsigned(rsp_ch.checksum_out)));
            check_field("data_out_0", want.d0, rsp_ch.data_out_0);
            check_field("data_out_1", want.d1, rsp_ch.data_out_1);
            check_field("data_out_2", 64'(want.d2), 64'(rsp_ch.data_out_2));
            check_field("timer_action", 64'(want.tmr), 64'(rsp_ch.timer_action));
            check_field("status", 64'(want.st), 64'(rsp_ch.status));
            check_field("last", 64'(want.last), 64'(rsp_ch.last));
         end
      end
      if (hold_left > 0) begin
         rsp_take <= 1'b0;
         hold_left--;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus: reset, the directed script, then the random phases, each
   // opened with a window register write while the block is idle.
   initial begin
      link_evt_type ev;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_MSG;
      req_ch.payload_0    <= '0;
      req_ch.payload_1    <= '0;
      req_ch.payload_2    <= '0;
      req_ch.ack_seq      <= '0;
      req_ch.ack_number   <= '0;
      req_ch.ack_checksum <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.data         <= '0;
      reset               <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         ev = '{script[i].mode, script[i].p0, script[i].p1, script[i].p2,
                script[i].aseq, script[i].anum, 32'd0};
         if (script[i].ck != CK_NONE)
            ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
         if (script[i].ck == CK_SKEW)
            ev.acks = ev.acks + 32'd1;
         offer_evt(ev, script[i].typed, script[i].tmr, script[i].st);
      end

      foreach (phase_plan[i]) begin
         wait_idle();
         set_window(phase_plan[i].win);
         idle_pct  = phase_plan[i].idle_pct;
         stall_pct = phase_plan[i].stall_pct;
         if (phase_plan[i].squeeze) begin
            // Clear the window, then stall the result side for a long
            // stretch while a burst of messages keeps coming. The result
            // queue fills, the input backs up, and the burst ends past a
            // full store so that some messages are refused. Full-window
            // expiries follow.
            if (in_flight() != 0) begin
               ev      = draw_evt();
               ev.mode = MODE_ACK;
               ev.anum = {1'b0, seq_next - 31'd1};
               ev.acks = frame_sum(ev.aseq, ev.anum, ev.p0, ev.p1, ev.p2);
               offer_evt(ev);
            end
            holds_asked++;
            repeat (DEPTH + 6) begin
               ev      = draw_evt();
               ev.mode = MODE_MSG;
               offer_evt(ev);
            end
            repeat (2) begin
               ev      = draw_evt();
               ev.mode = MODE_TIMER;
               offer_evt(ev);
            end
         end
         repeat (phase_plan[i].items)
            offer_evt(draw_evt());
      end

      req_ch.valid <= 1'b0;
      while (awaited_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/gbns_pkg.sv
sv/gbns_if.sv
sv/gbns_ram.sv
sv/go_back_n_sender.sv
dv/tb_go_back_n_sender.sv
